FILE: hdl/bpj_pkg.sv
// ----------------------------------------------------------------------------
// bpj_pkg: shared types and constants for the disparity back-projection block
// Field widths, register map, pipeline lane and beat structs, derived widths
// for the divider chain and the split multipliers.
// ----------------------------------------------------------------------------
package bpj_pkg;

	// design constants
	localparam int COORD_BITS     = 12;
	localparam int DISP_FRAC_BITS = 6;

	// field widths
	localparam int PIX_W   = 12;
	localparam int DISP_W  = 16;
	localparam int CFG_W   = 32;
	localparam int DIM_W   = 13;
	localparam int OUT_W   = 32;
	localparam int ADDR_W  = 5;
	localparam int Q_SHIFT = 28;

	// coordinate mask and outlier threshold (0.05 pixel)
	localparam logic [PIX_W-1:0]  COORD_MASK = PIX_W'((64'd1 << COORD_BITS) - 64'd1);
	localparam logic [DISP_W-1:0] DISP_LIMIT = DISP_W'((5 << DISP_FRAC_BITS) / 100);

	// quotient width, one divider cell per bit
	localparam int QW    = CFG_W + DISP_FRAC_BITS;
	// k * coordinate product and ray widths
	localparam int PK_W  = CFG_W + PIX_W + 1;
	localparam int RAY_W = CFG_W + PIX_W + 2;
	// split multiplier widths
	localparam int HM     = (RAY_W + 1) / 2;
	localparam int HD     = (QW + 1) / 2;
	localparam int MAG2   = 2 * HM;
	localparam int DEP2   = 2 * HD;
	localparam int PP_W   = HM + HD;
	localparam int SUM_W  = HM + 2 * HD;
	localparam int PROD_W = MAG2 + DEP2;

	// saturation limits
	localparam logic [OUT_W-1:0] SAT_POS = 32'h7fff_ffff;
	localparam logic [OUT_W-1:0] SAT_NEG = 32'h8000_0000;

	// register reset values
	localparam logic [DIM_W-1:0] RST_WIDTH  = 13'd640;
	localparam logic [DIM_W-1:0] RST_HEIGHT = 13'd480;
	localparam logic [CFG_W-1:0] RST_FB     = 32'h0000_0000;
	localparam logic [CFG_W-1:0] RST_ONE    = 32'h1000_0000;
	localparam logic [CFG_W-1:0] RST_ZERO   = 32'h0000_0000;

	typedef enum logic [1:0] {
		ST_GOOD    = 2'd0,
		ST_OOB     = 2'd1,
		ST_OUTLIER = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		REG_IMAGE_WIDTH    = 3'd0,
		REG_IMAGE_HEIGHT   = 3'd1,
		REG_FOCAL_BASELINE = 3'd2,
		REG_INV_K00        = 3'd3,
		REG_INV_K01        = 3'd4,
		REG_INV_K02        = 3'd5,
		REG_INV_K11        = 3'd6,
		REG_INV_K12        = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [DIM_W-1:0]        image_width;
		logic [DIM_W-1:0]        image_height;
		logic [CFG_W-1:0]        focal_baseline;
		logic signed [CFG_W-1:0] inv_k00;
		logic signed [CFG_W-1:0] inv_k01;
		logic signed [CFG_W-1:0] inv_k02;
		logic signed [CFG_W-1:0] inv_k11;
		logic signed [CFG_W-1:0] inv_k12;
	} cfg_t;

	typedef struct packed {
		logic [PIX_W-1:0]  pixel_column;
		logic [PIX_W-1:0]  pixel_row;
		logic [DISP_W-1:0] disparity_value;
	} pixel_t;

	typedef struct packed {
		logic [1:0]              status;
		logic signed [OUT_W-1:0] point_x;
		logic signed [OUT_W-1:0] point_y;
		logic signed [OUT_W-1:0] point_z;
	} point_t;

	// one item travelling down the divider chain
	typedef struct packed {
		status_t                 status;
		logic signed [RAY_W-1:0] ray_x;
		logic signed [RAY_W-1:0] ray_y;
		logic [DISP_W-1:0]       divisor;
		logic [DISP_W-1:0]       rem;
		logic [QW-1:0]           work;
	} lane_t;

endpackage

FILE: hdl/disparity_to_point_backproject.sv
// ----------------------------------------------------------------------------
// disparity_to_point_backproject: stereo disparity pixel to 3D point
// Turns each pixel beat into a point beat; one pixel per cycle while pixel_stall is low.
// The core is the 38-cell restoring divider chain, one quotient bit each.
// Reset clears all valids and the output skid, and loads register defaults.
// ----------------------------------------------------------------------------
module disparity_to_point_backproject (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [bpj_pkg::ADDR_W-1:0] paddr,
	input  logic [bpj_pkg::CFG_W-1:0]  pwdata,
	output logic [bpj_pkg::CFG_W-1:0]  prdata,
	output logic                       pready,
	input  logic                       pixel_valid,
	output logic                       pixel_stall,
	input  bpj_pkg::pixel_t            pixel,
	output logic                       point_valid,
	input  logic                       point_stall,
	output bpj_pkg::point_t            point
);

	localparam int QW = bpj_pkg::QW;

	bpj_pkg::cfg_t   cfg;
	logic            en;
	logic [QW:0]     chain_valid;
	bpj_pkg::lane_t  chain_lane [QW+1];
	logic            last_valid;
	bpj_pkg::point_t last_point;

	logic            out_valid_q;
	logic            skid_valid_q;
	bpj_pkg::point_t out_q;
	bpj_pkg::point_t skid_q;
	logic            pop;

	assign pready      = 1'b1;
	assign en          = ~skid_valid_q;
	assign pixel_stall = skid_valid_q;
	assign pop         = out_valid_q & ~point_stall;

	bpj_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	bpj_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.cfg      (cfg),
		.up_valid (pixel_valid),
		.up_pixel (pixel),
		.dn_valid (chain_valid[0]),
		.dn_lane  (chain_lane[0])
	);

	// divider chain, one quotient bit per cell
	for (genvar i = 0; i < QW; i++) begin : g_cell
		bpj_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.up_valid (chain_valid[i]),
			.up_lane  (chain_lane[i]),
			.dn_valid (chain_valid[i+1]),
			.dn_lane  (chain_lane[i+1])
		);
	end

	bpj_scale u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.up_valid (chain_valid[QW]),
		.up_lane  (chain_lane[QW]),
		.dn_valid (last_valid),
		.dn_point (last_point)
	);

	// output register with skid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop)
				skid_valid_q <= 1'b0;
		end else if (last_valid) begin
			if (!out_valid_q || pop)
				out_valid_q <= 1'b1;
			else
				skid_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop)
				out_q <= skid_q;
		end else if (last_valid) begin
			if (!out_valid_q || pop)
				out_q <= last_point;
			else
				skid_q <= last_point;
		end
	end

	assign point_valid = out_valid_q;
	assign point       = out_q;

endmodule

FILE: hdl/bpj_regs.sv
// ----------------------------------------------------------------------------
// bpj_regs: configuration register file
// APB-style write and read of image size, focal baseline and inverse
// intrinsic terms.
// ----------------------------------------------------------------------------
module bpj_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bpj_pkg::ADDR_W-1:0]    paddr,
	input  logic [bpj_pkg::CFG_W-1:0]     pwdata,
	output logic [bpj_pkg::CFG_W-1:0]     prdata,
	output bpj_pkg::cfg_t                 cfg
);

	bpj_pkg::cfg_t     cfg_q;
	bpj_pkg::reg_idx_t idx;
	logic              wr;

	assign idx = bpj_pkg::reg_idx_t'(paddr[bpj_pkg::ADDR_W-1:2]);
	assign wr  = psel & penable & pwrite;
	assign cfg = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width    <= bpj_pkg::RST_WIDTH;
			cfg_q.image_height   <= bpj_pkg::RST_HEIGHT;
			cfg_q.focal_baseline <= bpj_pkg::RST_FB;
			cfg_q.inv_k00        <= bpj_pkg::RST_ONE;
			cfg_q.inv_k01        <= bpj_pkg::RST_ZERO;
			cfg_q.inv_k02        <= bpj_pkg::RST_ZERO;
			cfg_q.inv_k11        <= bpj_pkg::RST_ONE;
			cfg_q.inv_k12        <= bpj_pkg::RST_ZERO;
		end else if (wr) begin
			case (idx)
				bpj_pkg::REG_IMAGE_WIDTH:    cfg_q.image_width    <= pwdata[bpj_pkg::DIM_W-1:0];
				bpj_pkg::REG_IMAGE_HEIGHT:   cfg_q.image_height   <= pwdata[bpj_pkg::DIM_W-1:0];
				bpj_pkg::REG_FOCAL_BASELINE: cfg_q.focal_baseline <= pwdata;
				bpj_pkg::REG_INV_K00:        cfg_q.inv_k00        <= pwdata;
				bpj_pkg::REG_INV_K01:        cfg_q.inv_k01        <= pwdata;
				bpj_pkg::REG_INV_K02:        cfg_q.inv_k02        <= pwdata;
				bpj_pkg::REG_INV_K11:        cfg_q.inv_k11        <= pwdata;
				bpj_pkg::REG_INV_K12:        cfg_q.inv_k12        <= pwdata;
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (idx)
			bpj_pkg::REG_IMAGE_WIDTH:    prdata = bpj_pkg::CFG_W'(cfg_q.image_width);
			bpj_pkg::REG_IMAGE_HEIGHT:   prdata = bpj_pkg::CFG_W'(cfg_q.image_height);
			bpj_pkg::REG_FOCAL_BASELINE: prdata = cfg_q.focal_baseline;
			bpj_pkg::REG_INV_K00:        prdata = cfg_q.inv_k00;
			bpj_pkg::REG_INV_K01:        prdata = cfg_q.inv_k01;
			bpj_pkg::REG_INV_K02:        prdata = cfg_q.inv_k02;
			bpj_pkg::REG_INV_K11:        prdata = cfg_q.inv_k11;
			bpj_pkg::REG_INV_K12:        prdata = cfg_q.inv_k12;
			default:                     prdata = '0;
		endcase
	end

endmodule

FILE: hdl/bpj_front.sv
// ----------------------------------------------------------------------------
// bpj_front: pixel classification and viewing ray
// Border and outlier checks, K-inverse times [u, v, 1], and loading of the
// first divider cell with the scaled focal baseline.
// ----------------------------------------------------------------------------
module bpj_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  bpj_pkg::cfg_t   cfg,
	input  logic            up_valid,
	input  bpj_pkg::pixel_t up_pixel,
	output logic            dn_valid,
	output bpj_pkg::lane_t  dn_lane
);

	logic [bpj_pkg::PIX_W-1:0] u_in;
	logic [bpj_pkg::PIX_W-1:0] v_in;
	logic                      oob;
	bpj_pkg::status_t          status_in;

	logic                       valid_s1, valid_s2, valid_s3;
	logic [bpj_pkg::PIX_W-1:0]  u_s1, v_s1;
	logic [bpj_pkg::DISP_W-1:0] d_s1, d_s2;
	bpj_pkg::status_t           status_s1, status_s2;

	logic signed [bpj_pkg::PK_W-1:0] pk00_s2, pk01_s2, pk11_s2;
	bpj_pkg::lane_t                  lane_s3;

	// border and small-disparity checks
	always_comb begin
		u_in = up_pixel.pixel_column & bpj_pkg::COORD_MASK;
		v_in = up_pixel.pixel_row & bpj_pkg::COORD_MASK;
		oob  = (u_in == '0) || (v_in == '0)
			|| (bpj_pkg::DIM_W'(u_in) + 13'd2 > cfg.image_width)
			|| (bpj_pkg::DIM_W'(v_in) + 13'd2 > cfg.image_height);
		if (oob)
			status_in = bpj_pkg::ST_OOB;
		else if (up_pixel.disparity_value <= bpj_pkg::DISP_LIMIT)
			status_in = bpj_pkg::ST_OUTLIER;
		else
			status_in = bpj_pkg::ST_GOOD;
	end

	// valid pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= up_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// stage 1: capture pixel, stage 2: k products, stage 3: ray sums
	always_ff @(posedge clk) begin
		if (en) begin
			u_s1      <= u_in;
			v_s1      <= v_in;
			d_s1      <= up_pixel.disparity_value;
			status_s1 <= status_in;

			pk00_s2   <= bpj_pkg::PK_W'($signed(cfg.inv_k00))
				* bpj_pkg::PK_W'($signed({1'b0, u_s1}));
			pk01_s2   <= bpj_pkg::PK_W'($signed(cfg.inv_k01))
				* bpj_pkg::PK_W'($signed({1'b0, v_s1}));
			pk11_s2   <= bpj_pkg::PK_W'($signed(cfg.inv_k11))
				* bpj_pkg::PK_W'($signed({1'b0, v_s1}));
			d_s2      <= d_s1;
			status_s2 <= status_s1;

			lane_s3.status  <= status_s2;
			lane_s3.ray_x   <= bpj_pkg::RAY_W'(pk00_s2) + bpj_pkg::RAY_W'(pk01_s2)
				+ bpj_pkg::RAY_W'($signed(cfg.inv_k02));
			lane_s3.ray_y   <= bpj_pkg::RAY_W'(pk11_s2)
				+ bpj_pkg::RAY_W'($signed(cfg.inv_k12));
			lane_s3.divisor <= d_s2;
			lane_s3.rem     <= '0;
			lane_s3.work    <= {cfg.focal_baseline, {bpj_pkg::DISP_FRAC_BITS{1'b0}}};
		end
	end

	assign dn_valid = valid_s3;
	assign dn_lane  = lane_s3;

endmodule

FILE: hdl/bpj_div_cell.sv
// ----------------------------------------------------------------------------
// bpj_div_cell: one restoring-division cell
// Shifts one dividend bit into the partial remainder, subtracts the
// disparity when it fits and shifts the quotient bit in.
// ----------------------------------------------------------------------------
module bpj_div_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           up_valid,
	input  bpj_pkg::lane_t up_lane,
	output logic           dn_valid,
	output bpj_pkg::lane_t dn_lane
);

	logic [bpj_pkg::DISP_W:0]   shifted;
	logic [bpj_pkg::DISP_W+1:0] diff;
	logic                       fits;
	bpj_pkg::lane_t             lane_n;
	logic                       valid_q;
	bpj_pkg::lane_t             lane_q;

	// trial subtract
	always_comb begin
		shifted     = {up_lane.rem, up_lane.work[bpj_pkg::QW-1]};
		diff        = {1'b0, shifted} - {2'b00, up_lane.divisor};
		fits        = ~diff[bpj_pkg::DISP_W+1];
		lane_n      = up_lane;
		lane_n.rem  = fits ? diff[bpj_pkg::DISP_W-1:0] : shifted[bpj_pkg::DISP_W-1:0];
		lane_n.work = {up_lane.work[bpj_pkg::QW-2:0], fits};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (en)
			valid_q <= up_valid;
	end

	always_ff @(posedge clk) begin
		if (en)
			lane_q <= lane_n;
	end

	assign dn_valid = valid_q;
	assign dn_lane  = lane_q;

endmodule

FILE: hdl/bpj_scale.sv
// ----------------------------------------------------------------------------
// bpj_scale: ray times depth with Q28 rescale and saturation
// Sign-magnitude split, four registered partial products per axis, two
// adder stages, then truncation toward zero and clamping to Q16.16.
// ----------------------------------------------------------------------------
module bpj_scale (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            up_valid,
	input  bpj_pkg::lane_t  up_lane,
	output logic            dn_valid,
	output bpj_pkg::point_t dn_point
);

	localparam int HM     = bpj_pkg::HM;
	localparam int HD     = bpj_pkg::HD;
	localparam int MAG2   = bpj_pkg::MAG2;
	localparam int DEP2   = bpj_pkg::DEP2;
	localparam int PP_W   = bpj_pkg::PP_W;
	localparam int SUM_W  = bpj_pkg::SUM_W;
	localparam int PROD_W = bpj_pkg::PROD_W;
	localparam int RAY_W  = bpj_pkg::RAY_W;
	localparam int OUT_W  = bpj_pkg::OUT_W;
	localparam int SH     = bpj_pkg::Q_SHIFT;

	// magnitude of a signed ray
	function automatic logic [MAG2-1:0] ray_mag(input logic signed [RAY_W-1:0] r);
		logic [RAY_W-1:0] a;
		begin
			a       = r[RAY_W-1] ? (~r + 1'b1) : r;
			ray_mag = MAG2'(a);
		end
	endfunction

	// product >> 28, truncated toward zero, clamped
	function automatic logic [OUT_W-1:0] sat_q(input logic neg, input logic [PROD_W-1:0] p);
		logic             over;
		logic [OUT_W-1:0] val;
		begin
			over = |p[PROD_W-1:SH+OUT_W-1];
			val  = {1'b0, p[SH+OUT_W-2:SH]};
			if (neg)
				sat_q = over ? bpj_pkg::SAT_NEG : (OUT_W'(0) - val);
			else
				sat_q = over ? bpj_pkg::SAT_POS : val;
		end
	endfunction

	logic signed [RAY_W-1:0] ray [2];

	logic [4:0]             valid_q;
	bpj_pkg::status_t       status_s1, status_s2, status_s3, status_s4;
	logic [OUT_W-1:0]       z_s1, z_s2, z_s3, z_s4;
	logic [1:0]             neg_s1, neg_s2, neg_s3, neg_s4;
	logic [MAG2-1:0]        mag_s1 [2];
	logic [DEP2-1:0]        dep_s1;
	logic [PP_W-1:0]        pp_ll_s2 [2];
	logic [PP_W-1:0]        pp_lh_s2 [2];
	logic [PP_W-1:0]        pp_hl_s2 [2];
	logic [PP_W-1:0]        pp_hh_s2 [2];
	logic [SUM_W-1:0]       slo_s3 [2];
	logic [SUM_W-1:0]       shi_s3 [2];
	logic [PROD_W-1:0]      prod_s4 [2];
	bpj_pkg::point_t        point_s5;

	assign ray[0] = up_lane.ray_x;
	assign ray[1] = up_lane.ray_y;

	// valid pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= '0;
		else if (en)
			valid_q <= {valid_q[3:0], up_valid};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// stage 1: sign split, depth clamp for z
			status_s1 <= up_lane.status;
			dep_s1    <= DEP2'(up_lane.work);
			z_s1      <= (|up_lane.work[bpj_pkg::QW-1:OUT_W-1]) ? bpj_pkg::SAT_POS
				: {1'b0, up_lane.work[OUT_W-2:0]};
			for (int a = 0; a < 2; a++) begin
				neg_s1[a] <= ray[a][RAY_W-1];
				mag_s1[a] <= ray_mag(ray[a]);
			end

			// stage 2: partial products
			status_s2 <= status_s1;
			z_s2      <= z_s1;
			neg_s2    <= neg_s1;
			for (int a = 0; a < 2; a++) begin
				pp_ll_s2[a] <= PP_W'(mag_s1[a][HM-1:0]) * PP_W'(dep_s1[HD-1:0]);
				pp_lh_s2[a] <= PP_W'(mag_s1[a][HM-1:0]) * PP_W'(dep_s1[DEP2-1:HD]);
				pp_hl_s2[a] <= PP_W'(mag_s1[a][MAG2-1:HM]) * PP_W'(dep_s1[HD-1:0]);
				pp_hh_s2[a] <= PP_W'(mag_s1[a][MAG2-1:HM]) * PP_W'(dep_s1[DEP2-1:HD]);
			end

			// stage 3: combine along depth halves
			status_s3 <= status_s2;
			z_s3      <= z_s2;
			neg_s3    <= neg_s2;
			for (int a = 0; a < 2; a++) begin
				slo_s3[a] <= SUM_W'(pp_ll_s2[a]) + (SUM_W'(pp_lh_s2[a]) << HD);
				shi_s3[a] <= SUM_W'(pp_hl_s2[a]) + (SUM_W'(pp_hh_s2[a]) << HD);
			end

			// stage 4: full product
			status_s4 <= status_s3;
			z_s4      <= z_s3;
			neg_s4    <= neg_s3;
			for (int a = 0; a < 2; a++)
				prod_s4[a] <= PROD_W'(slo_s3[a]) + (PROD_W'(shi_s3[a]) << HM);

			// stage 5: rescale, clamp, zero rejected pixels
			point_s5.status <= status_s4;
			if (status_s4 == bpj_pkg::ST_GOOD) begin
				point_s5.point_x <= sat_q(neg_s4[0], prod_s4[0]);
				point_s5.point_y <= sat_q(neg_s4[1], prod_s4[1]);
				point_s5.point_z <= z_s4;
			end else begin
				point_s5.point_x <= '0;
				point_s5.point_y <= '0;
				point_s5.point_z <= '0;
			end
		end
	end

	assign dn_valid = valid_q[4];
	assign dn_point = point_s5;

endmodule
